// File: sv/mrpt_pkg.sv
`timescale 1ns / 1ps

package mrpt_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int OUT_DATA_W       = 8;
    localparam int NUM_TRIAL        = 3;
    localparam int NUM_BASES        = 3;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIV   = 9'b000000010,
        ST_SPLIT = 9'b000000100,
        ST_BMOD  = 9'b000001000,
        ST_EXP   = 9'b000010000,
        ST_MUL   = 9'b000100000,
        ST_SQ    = 9'b001000000,
        ST_CHK   = 9'b010000000,
        ST_LOOP  = 9'b100000000
    } state_t;

    // modular multiplier status
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

    // trial divisors after the even check
    function automatic logic [7:0] trial_prime(input logic [1:0] idx);
        logic [7:0] p;
        case (idx)
            2'd0:    p = 8'd3;
            2'd1:    p = 8'd5;
            2'd2:    p = 8'd7;
            default: p = 8'd7;
        endcase
        return p;
    endfunction

    // witness bases, exact below 2^32
    function automatic logic [7:0] witness_base(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'd2;
            2'd1:    b = 8'd7;
            2'd2:    b = 8'd61;
            default: b = 8'd61;
        endcase
        return b;
    endfunction

endpackage

// File: sv/mrpt_mulmod.sv
`timescale 1ns / 1ps

// bit-serial modular multiply, a < m required, one bit of b per cycle
module mrpt_mulmod #(
    parameter int W = mrpt_pkg::NUMBER_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    input  logic [W-1:0]      m,
    output mrpt_pkg::mm_stat_t stat,
    output logic [W-1:0]      result
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;
    logic [W-1:0]  r_reg, r_next;

    logic [W+1:0]  t;
    logic [W+1:0]  m1;
    logic [W+1:0]  m2;
    logic [W+1:0]  tm1;
    logic [W+1:0]  tm2;
    logic [W-1:0]  r_step;

    // 2r + bit*a stays below 3m, so at most two subtractions
    always_comb
    begin
        t      = {1'b0, r_reg, 1'b0} + (b_reg[W-1] ? {2'b00, a_reg} : '0);
        m1     = {2'b00, m_reg};
        m2     = {1'b0, m_reg, 1'b0};
        tm1    = t - m1;
        tm2    = t - m2;
        if (t >= m2)
        begin
            r_step = tm2[W-1:0];
        end
        else if (t >= m1)
        begin
            r_step = tm1[W-1:0];
        end
        else
        begin
            r_step = t[W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            a_next    = a;
            b_next    = b;
            m_next    = m;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next = r_step;
            b_next = {b_reg[W-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = r_reg;

endmodule

// File: sv/mrpt_ctrl.sv
`timescale 1ns / 1ps

// test sequencer, drives the shared modular multiplier
module mrpt_ctrl #(
    parameter int W = mrpt_pkg::NUMBER_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [W-1:0]       number,
    output logic               idle,
    output logic               fin_valid,
    output logic               fin_prime,
    output logic               mm_go,
    output logic [W-1:0]       mm_a,
    output logic [W-1:0]       mm_b,
    output logic [W-1:0]       mm_m,
    input  mrpt_pkg::mm_stat_t mm_stat,
    input  logic [W-1:0]       mm_result
);

    localparam int SW = (W > 1) ? $clog2(W) : 1;

    mrpt_pkg::state_t st_reg, st_next;
    logic          go_reg, go_next;
    logic          fin_valid_reg, fin_valid_next;
    logic          fin_prime_reg, fin_prime_next;
    logic [1:0]    idx_reg, idx_next;
    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  d_reg, d_next;
    logic [SW-1:0] s_reg, s_next;
    logic [SW-1:0] k_reg, k_next;
    logic [W-1:0]  sq_reg, sq_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  e_reg, e_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  m_reg, m_next;

    logic [W-1:0]  nm1;
    logic          pass;
    logic          fail;

    assign nm1 = n_reg - 1'b1;

    always_comb
    begin
        st_next        = st_reg;
        go_next        = 1'b0;
        fin_valid_next = 1'b0;
        fin_prime_next = fin_prime_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        m_next         = m_reg;
        pass           = 1'b0;
        fail           = 1'b0;

        case (st_reg)
            mrpt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    n_next = number;
                    if (number < W'(2))
                    begin
                        fail = 1'b1;
                    end
                    else if (number == W'(2) || number == W'(3) ||
                             number == W'(5) || number == W'(7))
                    begin
                        fin_valid_next = 1'b1;
                        fin_prime_next = 1'b1;
                    end
                    else if (!number[0])
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        // n mod p as 1 * n mod p
                        idx_next = 2'd0;
                        go_next  = 1'b1;
                        a_next   = W'(1);
                        b_next   = number;
                        m_next   = W'(mrpt_pkg::trial_prime(2'd0));
                        st_next  = mrpt_pkg::ST_DIV;
                    end
                end
            end

            mrpt_pkg::ST_DIV:
            begin
                if (mm_stat.done)
                begin
                    if (mm_result == '0)
                    begin
                        fail = 1'b1;
                    end
                    else if (idx_reg == 2'(mrpt_pkg::NUM_TRIAL - 1))
                    begin
                        d_next  = nm1;
                        s_next  = '0;
                        st_next = mrpt_pkg::ST_SPLIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                        go_next  = 1'b1;
                        a_next   = W'(1);
                        b_next   = n_reg;
                        m_next   = W'(mrpt_pkg::trial_prime(idx_reg + 2'd1));
                    end
                end
            end

            mrpt_pkg::ST_SPLIT:
            begin
                // strip trailing zeros of n-1, one per cycle
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    idx_next = 2'd0;
                    go_next  = 1'b1;
                    a_next   = W'(1);
                    b_next   = W'(mrpt_pkg::witness_base(2'd0));
                    m_next   = n_reg;
                    st_next  = mrpt_pkg::ST_BMOD;
                end
            end

            mrpt_pkg::ST_BMOD:
            begin
                if (mm_stat.done)
                begin
                    // base that is a multiple of n is skipped
                    if (mm_result == '0)
                    begin
                        pass = 1'b1;
                    end
                    else
                    begin
                        sq_next  = mm_result;
                        acc_next = W'(1);
                        e_next   = d_reg;
                        st_next  = mrpt_pkg::ST_EXP;
                    end
                end
            end

            mrpt_pkg::ST_EXP:
            begin
                if (e_reg == '0)
                begin
                    st_next = mrpt_pkg::ST_CHK;
                end
                else if (e_reg[0])
                begin
                    go_next = 1'b1;
                    a_next  = acc_reg;
                    b_next  = sq_reg;
                    m_next  = n_reg;
                    st_next = mrpt_pkg::ST_MUL;
                end
                else
                begin
                    go_next = 1'b1;
                    a_next  = sq_reg;
                    b_next  = sq_reg;
                    m_next  = n_reg;
                    st_next = mrpt_pkg::ST_SQ;
                end
            end

            mrpt_pkg::ST_MUL:
            begin
                if (mm_stat.done)
                begin
                    acc_next = mm_result;
                    // last exponent bit needs no further squaring
                    if (e_reg[W-1:1] == '0)
                    begin
                        st_next = mrpt_pkg::ST_CHK;
                    end
                    else
                    begin
                        go_next = 1'b1;
                        a_next  = sq_reg;
                        b_next  = sq_reg;
                        m_next  = n_reg;
                        st_next = mrpt_pkg::ST_SQ;
                    end
                end
            end

            mrpt_pkg::ST_SQ:
            begin
                if (mm_stat.done)
                begin
                    sq_next = mm_result;
                    e_next  = e_reg >> 1;
                    st_next = mrpt_pkg::ST_EXP;
                end
            end

            mrpt_pkg::ST_CHK:
            begin
                if (acc_reg == W'(1) || acc_reg == nm1)
                begin
                    pass = 1'b1;
                end
                else if (s_reg > SW'(1))
                begin
                    k_next  = SW'(1);
                    go_next = 1'b1;
                    a_next  = acc_reg;
                    b_next  = acc_reg;
                    m_next  = n_reg;
                    st_next = mrpt_pkg::ST_LOOP;
                end
                else
                begin
                    fail = 1'b1;
                end
            end

            mrpt_pkg::ST_LOOP:
            begin
                if (mm_stat.done)
                begin
                    acc_next = mm_result;
                    if (mm_result == nm1)
                    begin
                        pass = 1'b1;
                    end
                    else if (({1'b0, k_reg} + 1'b1) < {1'b0, s_reg})
                    begin
                        k_next  = k_reg + 1'b1;
                        go_next = 1'b1;
                        a_next  = mm_result;
                        b_next  = mm_result;
                        m_next  = n_reg;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
            end

            default:
            begin
                st_next = mrpt_pkg::ST_IDLE;
            end
        endcase

        if (fail)
        begin
            fin_valid_next = 1'b1;
            fin_prime_next = 1'b0;
            st_next        = mrpt_pkg::ST_IDLE;
        end
        else if (pass)
        begin
            if (idx_reg == 2'(mrpt_pkg::NUM_BASES - 1))
            begin
                fin_valid_next = 1'b1;
                fin_prime_next = 1'b1;
                st_next        = mrpt_pkg::ST_IDLE;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
                go_next  = 1'b1;
                a_next   = W'(1);
                b_next   = W'(mrpt_pkg::witness_base(idx_reg + 2'd1));
                m_next   = n_reg;
                st_next  = mrpt_pkg::ST_BMOD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= mrpt_pkg::ST_IDLE;
            go_reg        <= 1'b0;
            fin_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            st_reg        <= st_next;
            go_reg        <= go_next;
            fin_valid_reg <= fin_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_prime_reg <= fin_prime_next;
        n_reg         <= n_next;
        d_reg         <= d_next;
        s_reg         <= s_next;
        k_reg         <= k_next;
        sq_reg        <= sq_next;
        acc_reg       <= acc_next;
        e_reg         <= e_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        m_reg         <= m_next;
    end

    assign idle      = (st_reg == mrpt_pkg::ST_IDLE);
    assign fin_valid = fin_valid_reg;
    assign fin_prime = fin_prime_reg;
    assign mm_go     = go_reg;
    assign mm_a      = a_reg;
    assign mm_b      = b_reg;
    assign mm_m      = m_reg;

endmodule

// File: sv/miller_rabin_prime_test_core.sv
// every modular multiply runs on the shared bit-serial unit
// even values and values below 8 are answered without the multiplier, other multiples
// of 3, 5, 7 end in trial division; full tests take up to about 3 * 2 * NUMBER_WIDTH
// multiplies; one item at a time, the next is taken once the sequencer is idle
// and the result register is free or draining
// reset: asynchronous active-low, clears sequencer, multiplier control and output valid
`timescale 1ns / 1ps

module miller_rabin_prime_test_core #(
    parameter int NUMBER_WIDTH = mrpt_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((NUMBER_WIDTH + 7) / 8) * 8 - 1:0] s_tdata, // number
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mrpt_pkg::OUT_DATA_W-1:0]     m_tdata   // is_prime, zero fill above
);

    logic                     accept;
    logic                     ctrl_idle;
    logic                     fin_valid;
    logic                     fin_prime;
    logic                     mm_go;
    logic [NUMBER_WIDTH-1:0]  mm_a;
    logic [NUMBER_WIDTH-1:0]  mm_b;
    logic [NUMBER_WIDTH-1:0]  mm_m;
    logic [NUMBER_WIDTH-1:0]  mm_result;
    mrpt_pkg::mm_stat_t       mm_stat;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_prime_reg, out_prime_next;

    // take a new item only when the sequencer is idle, no answer is still
    // on its way into the output register, and that register is free or draining
    assign s_tready = ctrl_idle && !fin_valid && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // sequencer: trial division, n-1 split, witness rounds
    mrpt_ctrl #(
        .W (NUMBER_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .number    (s_tdata[NUMBER_WIDTH-1:0]),
        .idle      (ctrl_idle),
        .fin_valid (fin_valid),
        .fin_prime (fin_prime),
        .mm_go     (mm_go),
        .mm_a      (mm_a),
        .mm_b      (mm_b),
        .mm_m      (mm_m),
        .mm_stat   (mm_stat),
        .mm_result (mm_result)
    );

    // the one arithmetic unit: shift-add modular multiply, also serves n mod p
    mrpt_mulmod #(
        .W (NUMBER_WIDTH)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_go),
        .a      (mm_a),
        .b      (mm_b),
        .m      (mm_m),
        .stat   (mm_stat),
        .result (mm_result)
    );

    // output register holds the answer until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        if (fin_valid)
        begin
            out_valid_next = 1'b1;
            out_prime_next = fin_prime;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_prime_reg <= out_prime_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mrpt_pkg::OUT_DATA_W - 1){1'b0}}, out_prime_reg};

`ifndef SYNTHESIS
    // an accepted item keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
    else $error("item accepted back to back");

    // a finished answer never overwrites one still waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid |-> (!out_valid_reg || $past(m_tready)))
    else $error("answer overwrote a pending output");

    // the multiplier is never restarted while it is working
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_go |-> !mm_stat.busy)
    else $error("multiplier started while busy");

    // multiplier results only arrive while a test is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_stat.done |-> !ctrl_idle)
    else $error("multiplier result with idle sequencer");
`endif

endmodule
